// ===== rtl/btkt_pkg.sv =====
// ----------------------------------------------------------------------------
// btkt_pkg - shared types and constants of the block TEA key transform
// Field widths, register codes, queue word layout, back-end states and the
// round count table.
// ----------------------------------------------------------------------------
package btkt_pkg;

    localparam int DATA_W      = 32;
    localparam int LEN_W       = 4;
    localparam int ROUNDS_W    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DATA_W-1:0] TEA_DELTA   = 32'h9E37_79B9;
    localparam logic [DATA_W-1:0] SEED0_RESET = 32'hFBA7_FB42;
    localparam logic [DATA_W-1:0] SEED1_RESET = 32'h0032_092B;
    localparam logic [DATA_W-1:0] SEED2_RESET = 32'hC2BE_1B5E;
    localparam logic [DATA_W-1:0] SEED3_RESET = 32'h1645_82DB;
    localparam logic [LEN_W-1:0]  BLOCK_WORDS_RESET = 4'd4;
    localparam logic [LEN_W-1:0]  CHAIN_LEN   = 4'd4;

    typedef logic [3:0][DATA_W-1:0] key_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED0       = 3'd0,
        CFG_SEED1       = 3'd1,
        CFG_SEED2       = 3'd2,
        CFG_SEED3       = 3'd3,
        CFG_BLOCK_WORDS = 3'd4,
        CFG_CHAIN_MODE  = 3'd5
    } cfg_reg_t;

    // one classified input word on its way to the back end
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  pos;
        logic              reload;
        logic              done;
        logic [LEN_W-1:0]  len;
    } queue_word_t;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_RUN,
        BK_EMIT
    } back_state_t;

    // 52/n + 6 for the legal block lengths
    function automatic logic [ROUNDS_W-1:0] rounds_for(input logic [LEN_W-1:0] len);
        logic [ROUNDS_W-1:0] r;
        unique case (len)
            4'd2:    r = 6'd32;
            4'd3:    r = 6'd23;
            4'd4:    r = 6'd19;
            4'd5:    r = 6'd16;
            4'd6:    r = 6'd14;
            4'd7:    r = 6'd13;
            4'd8:    r = 6'd12;
            4'd9:    r = 6'd11;
            4'd10:   r = 6'd11;
            4'd11:   r = 6'd10;
            4'd12:   r = 6'd10;
            4'd13:   r = 6'd10;
            4'd14:   r = 6'd9;
            4'd15:   r = 6'd9;
            default: r = 6'd32;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/btkt_front.sv =====
// ----------------------------------------------------------------------------
// btkt_front - input side of the block TEA key transform
// Counts loaded words, tags the first and completing word of each block and
// pushes classified words into the queue.
// ----------------------------------------------------------------------------
module btkt_front
    import btkt_pkg::*;
#(
    parameter int MAX_WORDS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [DATA_W-1:0]   data_word,
    input  logic                reload_key,
    input  logic [LEN_W-1:0]    block_words,
    input  logic                q_full,
    output logic                q_push,
    output queue_word_t         q_word
);

    localparam int LEN_MAX = (MAX_WORDS < 15) ? MAX_WORDS : 15;

    logic [LEN_W-1:0] loaded_count_reg;
    logic [LEN_W-1:0] loaded_count_next;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W:0]   count_inc;
    logic             done;

    always_comb
    begin
        priority if (block_words < 4'd2)
            eff_len = 4'd2;
        else if (block_words > LEN_W'(LEN_MAX))
            eff_len = LEN_W'(LEN_MAX);
        else
            eff_len = block_words;
    end

    assign count_inc = {1'b0, loaded_count_reg} + 5'd1;
    assign done      = (count_inc >= {1'b0, eff_len});
    assign in_stall  = q_full;
    assign q_push    = in_valid && !q_full;

    always_comb
    begin
        q_word.data   = data_word;
        q_word.pos    = loaded_count_reg;
        q_word.reload = (loaded_count_reg == '0) && reload_key;
        q_word.done   = done;
        q_word.len    = eff_len;
    end

    always_comb
    begin
        loaded_count_next = loaded_count_reg;
        if (q_push)
            loaded_count_next = done ? '0 : count_inc[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loaded_count_reg <= '0;
        else
            loaded_count_reg <= loaded_count_next;
    end

endmodule

// ===== rtl/btkt_queue.sv =====
// ----------------------------------------------------------------------------
// btkt_queue - short queue between front and back end
// Two-entry FIFO of classified words.
// ----------------------------------------------------------------------------
module btkt_queue
    import btkt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_word_t  push_word,
    output logic         full,
    input  logic         pop,
    output logic         avail,
    output queue_word_t  pop_word
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_word_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign avail    = (count_reg != '0);
    assign pop_word = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== rtl/btkt_back.sv =====
// ----------------------------------------------------------------------------
// btkt_back - transform engine of the block TEA key transform
// Loads queued words into a rotating block buffer, runs the rounds with one
// mix unit, one word update per cycle, then streams the result words out.
// ----------------------------------------------------------------------------
module btkt_back
    import btkt_pkg::*;
#(
    parameter int MAX_WORDS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_avail,
    input  queue_word_t         q_word,
    output logic                q_pop,
    input  key_t                seed_key,
    input  logic                chain_mode,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DATA_W-1:0]   result_word,
    output logic                last_word
);

    localparam int LEN_MAX   = (MAX_WORDS < 15) ? MAX_WORDS : 15;
    localparam int BUF_DEPTH = (LEN_MAX < 4) ? 4 : LEN_MAX;
    localparam int IDX_W     = $clog2(BUF_DEPTH);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [DATA_W-1:0]    buf_reg [BUF_DEPTH];
    key_t                 key_reg;
    logic [DATA_W-1:0]    sum_reg;
    logic [DATA_W-1:0]    prev_reg;
    logic [LEN_W-1:0]     pos_reg;
    logic [ROUNDS_W-1:0]  rounds_reg;
    logic [LEN_W-1:0]     len_reg;

    logic                 load_en;
    logic                 run_en;
    logic                 emit_en;
    logic                 shift_en;
    logic                 step_last;
    logic                 round_last;
    logic                 pos_last;
    logic [1:0]           key_idx;
    logic [DATA_W-1:0]    mix;
    logic [DATA_W-1:0]    upd;
    logic [DATA_W-1:0]    ins;
    logic [LEN_W-1:0]     q_len_m1;

    assign pos_last   = (pos_reg == len_reg - 1'b1);
    assign step_last  = pos_last;
    assign round_last = (rounds_reg == ROUNDS_W'(1));
    assign q_len_m1   = q_word.len - 1'b1;

    assign key_idx = sum_reg[3:2] ^ pos_reg[1:0];
    assign mix     = (sum_reg + key_reg[key_idx])
                   ^ (prev_reg + ((prev_reg << 4) ^ (prev_reg >> 5)));
    assign upd     = buf_reg[0] + mix;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_LOAD:
                if (q_avail && q_word.done)
                    state_next = BK_RUN;
            BK_RUN:
                if (step_last && round_last)
                    state_next = BK_EMIT;
            BK_EMIT:
                if (!out_stall && pos_last)
                    state_next = BK_LOAD;
            default:
                state_next = BK_LOAD;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        out_valid = 1'b0;
        load_en   = 1'b0;
        run_en    = 1'b0;
        emit_en   = 1'b0;
        unique case (state_reg)
            BK_LOAD:
            begin
                q_pop   = q_avail;
                load_en = q_avail;
            end
            BK_RUN:
                run_en = 1'b1;
            BK_EMIT:
            begin
                out_valid = 1'b1;
                emit_en   = !out_stall;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign shift_en    = run_en || emit_en;
    assign ins         = run_en ? upd : buf_reg[0];
    assign result_word = buf_reg[0];
    assign last_word   = pos_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_LOAD;
            key_reg    <= {SEED3_RESET, SEED2_RESET, SEED1_RESET, SEED0_RESET};
            pos_reg    <= '0;
            rounds_reg <= '0;
            len_reg    <= BLOCK_WORDS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (load_en)
            begin
                if (q_word.reload)
                    key_reg <= seed_key;
                if (q_word.done)
                begin
                    pos_reg    <= '0;
                    len_reg    <= q_word.len;
                    rounds_reg <= rounds_for(q_word.len);
                end
            end
            else if (run_en)
            begin
                if (step_last)
                begin
                    pos_reg    <= '0;
                    rounds_reg <= rounds_reg - 1'b1;
                end
                else
                    pos_reg <= pos_reg + 1'b1;
            end
            else if (emit_en)
            begin
                pos_reg <= pos_reg + 1'b1;
                // buffer is rotated by three here: word 3 sits at the head
                if (pos_last && chain_mode && (len_reg == CHAIN_LEN))
                    key_reg <= {buf_reg[0], buf_reg[3], buf_reg[2], buf_reg[1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            buf_reg[q_word.pos[IDX_W-1:0]] <= q_word.data;
            if (q_word.done)
            begin
                sum_reg  <= TEA_DELTA;
                prev_reg <= (q_word.pos == q_len_m1) ? q_word.data
                                                     : buf_reg[q_len_m1[IDX_W-1:0]];
            end
        end
        if (run_en)
        begin
            prev_reg <= upd;
            if (step_last)
                sum_reg <= sum_reg + TEA_DELTA;
        end
        if (shift_en)
        begin
            for (int i = 0; i < BUF_DEPTH; i++)
            begin
                if (i == int'(len_reg) - 1)
                    buf_reg[i] <= ins;
                else if (i < int'(len_reg) - 1)
                    buf_reg[i] <= buf_reg[(i + 1) % BUF_DEPTH];
            end
        end
    end

endmodule

// ===== rtl/block_tea_key_transform.sv =====
// ----------------------------------------------------------------------------
// block_tea_key_transform - word-serial Block-TEA style transform
// Top level: configuration registers, front end, queue and transform engine.
// ----------------------------------------------------------------------------
// A block of n words (n = block_words clamped to 2..MAX_WORDS) is taken one
// word per cycle; the front end keeps accepting while a queue slot is free.
// Once the last word is in, the engine runs (52/n + 6) rounds of n word
// updates through a single mix-and-add unit, one update per cycle, then
// offers the n result words one per cycle while out_stall is low, last_word
// marking the final one. The shared update unit bounds the throughput.
// reload_key on the first word of a block copies the seed key into the
// working key; in chain mode a four-word result becomes the next working
// key. Seed writes take effect on reload only.
module block_tea_key_transform
    import btkt_pkg::*;
#(
    parameter int MAX_WORDS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DATA_W-1:0]     data_word,
    input  logic                  reload_key,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_W-1:0]     result_word,
    output logic                  last_word
);

    key_t              seed_key_reg;
    logic [LEN_W-1:0]  block_words_reg;
    logic              chain_mode_reg;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_avail;
    queue_word_t       push_word;
    queue_word_t       pop_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_key_reg    <= {SEED3_RESET, SEED2_RESET, SEED1_RESET, SEED0_RESET};
            block_words_reg <= BLOCK_WORDS_RESET;
            chain_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SEED0:       seed_key_reg[0] <= cfg_data;
                CFG_SEED1:       seed_key_reg[1] <= cfg_data;
                CFG_SEED2:       seed_key_reg[2] <= cfg_data;
                CFG_SEED3:       seed_key_reg[3] <= cfg_data;
                CFG_BLOCK_WORDS: block_words_reg <= cfg_data[LEN_W-1:0];
                CFG_CHAIN_MODE:  chain_mode_reg  <= cfg_data[0];
                default:         chain_mode_reg  <= chain_mode_reg;
            endcase
        end
    end

    btkt_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .reload_key  (reload_key),
        .block_words (block_words_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_word      (push_word)
    );

    btkt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_word  (pop_word)
    );

    btkt_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_avail     (q_avail),
        .q_word      (pop_word),
        .q_pop       (q_pop),
        .seed_key    (seed_key_reg),
        .chain_mode  (chain_mode_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_word (result_word),
        .last_word   (last_word)
    );

    a_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word |=> !out_valid)
        else $error("result stream continued past the last word");

    a_done_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && pop_word.done |=> !q_pop && !out_valid)
        else $error("engine did not start the transform after the completing word");

    a_no_pop_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !q_pop)
        else $error("queue popped while results are pending");

    a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_avail |=> q_avail)
        else $error("accepted word lost on its way into the queue");

endmodule

// ===== tb/tb_block_tea_key_transform.sv =====
// ----------------------------------------------------------------------------
// tb_block_tea_key_transform - self-checking bench for the block TEA transform
// Streams plaintext words through the engine under a range of key, length and
// chain settings. A scoreboard recomputes every block's rounds from its own
// copy of the registers and working key, and checks each emitted word and
// its last_word flag in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_block_tea_key_transform
    import btkt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WORDS    = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 250;
    localparam int HOLD_CYCLES  = 600;
    localparam int RAND_PHASES  = 8;
    localparam int HOLD_PHASE   = 5;
    localparam int PAUSE_PHASE  = 6;

    typedef struct {
        logic [DATA_W-1:0] word;
        logic              last;
    } tea_result_t;

    class tea_block_board;
        logic [DATA_W-1:0] seed_key [4];
        logic [LEN_W-1:0]  len_reg;
        logic              chain_on;
        logic [DATA_W-1:0] block_buf [MAX_WORDS];
        logic [DATA_W-1:0] work_key [4];
        int unsigned       loaded;
        tea_result_t       due_words [$];
        int unsigned       mismatches;
        int unsigned       blocks_done;
        int unsigned       words_taken;
        int unsigned       words_checked;

        function new();
            seed_key[0] = SEED0_RESET;
            seed_key[1] = SEED1_RESET;
            seed_key[2] = SEED2_RESET;
            seed_key[3] = SEED3_RESET;
            len_reg     = BLOCK_WORDS_RESET;
            chain_on    = 1'b0;
            work_key    = seed_key;
            loaded      = 0;
            foreach (block_buf[i])
                block_buf[i] = '0;
        endfunction

        function int unsigned eff_len();
            if (len_reg < 2)
                return 2;
            if (len_reg > MAX_WORDS)
                return MAX_WORDS;
            return len_reg;
        endfunction

        function void set_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
            case (idx)
                CFG_SEED0:       seed_key[0] = val;
                CFG_SEED1:       seed_key[1] = val;
                CFG_SEED2:       seed_key[2] = val;
                CFG_SEED3:       seed_key[3] = val;
                CFG_BLOCK_WORDS: len_reg = val[LEN_W-1:0];
                CFG_CHAIN_MODE:  chain_on = val[0];
                default:         ;
            endcase
        endfunction

        function void mix_block(input int unsigned n);
            logic [DATA_W-1:0] sum;
            logic [DATA_W-1:0] prev;
            logic [DATA_W-1:0] mix;
            logic [1:0]        ki;
            int unsigned       rounds;
            sum    = '0;
            prev   = block_buf[n-1];
            rounds = 52 / n + 6;
            repeat (rounds)
            begin
                sum = sum + TEA_DELTA;
                for (int unsigned p = 0; p < n; p++)
                begin
                    ki  = sum[3:2] ^ 2'(p & 3);
                    mix = (sum + work_key[ki]) ^ (prev + ((prev << 4) ^ (prev >> 5)));
                    block_buf[p] = block_buf[p] + mix;
                    prev = block_buf[p];
                end
            end
        endfunction

        function void take_word(input logic [DATA_W-1:0] data, input logic reload);
            int unsigned n;
            n = eff_len();
            words_taken++;
            if (loaded == 0 && reload)
                work_key = seed_key;
            if (loaded < MAX_WORDS)
                block_buf[loaded] = data;
            loaded++;
            if (loaded < n)
                return;
            mix_block(n);
            for (int unsigned i = 0; i < n; i++)
                due_words.push_back('{block_buf[i], (i == n - 1)});
            if (chain_on && n == 4)
                for (int k = 0; k < 4; k++)
                    work_key[k] = block_buf[k];
            loaded = 0;
            blocks_done++;
        endfunction

        function void check_word(input logic [DATA_W-1:0] got_word, input logic got_last);
            tea_result_t want;
            if (due_words.size() == 0)
            begin
                mismatches++;
                $error("result_word with nothing due: actual %h", got_word);
                return;
            end
            want = due_words.pop_front();
            words_checked++;
            if (got_word !== want.word)
            begin
                mismatches++;
                $error("result_word: expected %h, actual %h", want.word, got_word);
            end
            if (got_last !== want.last)
            begin
                mismatches++;
                $error("last_word: expected %b, actual %b", want.last, got_last);
            end
        endfunction

        function int unsigned pending();
            return due_words.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] data_word = '0;
    logic              reload_key = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] result_word;
    logic              last_word;

    int unsigned       gap_pct = 0;
    int unsigned       stall_pct = 0;
    logic              long_hold = 1'b0;
    int unsigned       hold_count = 0;
    int unsigned       cycles = 0;
    int unsigned       settings_used = 0;

    tea_block_board board = new();

    block_tea_key_transform #(.MAX_WORDS(MAX_WORDS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .reload_key  (reload_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_word (result_word),
        .last_word   (last_word)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_block_tea_key_transform: FAIL");
            $finish;
        end
    end

    // receiver: check each accepted word, then pick the next stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                board.check_word(result_word, last_word);
            if (long_hold && hold_count < HOLD_CYCLES)
            begin
                hold_count <= hold_count + 1;
                out_stall  <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_word(input logic [DATA_W-1:0] data, input logic reload);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= data;
        reload_key <= reload;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_word(data, reload);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_setting(input logic [DATA_W-1:0] keys [4],
                                 input logic [LEN_W-1:0] len, input logic chain);
        write_reg(CFG_SEED0, keys[0]);
        write_reg(CFG_SEED1, keys[1]);
        write_reg(CFG_SEED2, keys[2]);
        write_reg(CFG_SEED3, keys[3]);
        write_reg(CFG_BLOCK_WORDS, DATA_W'(len));
        write_reg(CFG_CHAIN_MODE, DATA_W'(chain));
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // hold the input and wait for every due word, then let the engine settle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [DATA_W-1:0] keys [4];
        logic [LEN_W-1:0]  len;
        logic              chain;
        int unsigned       n;
        int unsigned       nblocks;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key, four words: field extremes, then a reload on the first
        // and a second, ignored, reload on the next word
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(pick_data(), 1'b1);
        send_word(pick_data(), 1'b1);
        send_word(pick_data(), 1'b0);
        send_word(pick_data(), 1'b0);
        settle();

        // zero key, length below range, chain on with a two-word block
        keys = '{32'h0, 32'h0, 32'h0, 32'h0};
        apply_setting(keys, 4'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        settle();

        // all-ones key, length above range; shorten the length mid-block
        keys = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        apply_setting(keys, 4'd15, 1'b0);
        send_word(pick_data(), 1'b1);
        repeat (4) send_word(pick_data(), 1'b0);
        settle();
        write_reg(CFG_BLOCK_WORDS, DATA_W'(4'd1));
        cfg_write <= 1'b0;
        send_word(pick_data(), 1'b0);
        settle();

        // lengthen mid-block
        write_reg(CFG_BLOCK_WORDS, DATA_W'(4'd3));
        cfg_write <= 1'b0;
        send_word(pick_data(), 1'b1);
        settle();
        write_reg(CFG_BLOCK_WORDS, DATA_W'(4'd6));
        cfg_write <= 1'b0;
        repeat (5) send_word(pick_data(), 1'b0);
        settle();

        for (int k = 0; k < RAND_PHASES; k++)
        begin
            case (k)
                0:       len = 4'd2;
                1:       len = 4'd8;
                2:       len = 4'd4;
                3:       len = 4'd4;
                default: len = LEN_W'($urandom_range(15));
            endcase
            chain = (k == 2 || k == 3) ? 1'b1 : 1'($urandom_range(1));
            for (int j = 0; j < 4; j++)
            begin
                if (k == 3)
                    keys[j] = '0;
                else if (k == 4)
                    keys[j] = '1;
                else
                    keys[j] = $urandom;
            end
            apply_setting(keys, len, chain);

            case (k % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 59; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase

            n = board.eff_len();
            nblocks = (16 + n - 1) / n;
            if (k == HOLD_PHASE)
                long_hold <= 1'b1;
            for (int b = 0; b < nblocks; b++)
            begin
                if (k == PAUSE_PHASE && b == nblocks / 2)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (board.pending() != 0)
                        @(posedge clk);
                end
                for (int w = 0; w < n; w++)
                begin
                    if (w == 0)
                        send_word(pick_data(), ($urandom_range(2) == 0));
                    else
                        send_word(pick_data(), ($urandom_range(9) == 0));
                end
            end
            settle();
        end

        $display("Covered %0d blocks, %0d result words checked, from %0d input words",
                 board.blocks_done, board.words_checked, board.words_taken);
        $display("over %0d register settings, every idle pattern and a long output hold.",
                 settings_used);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_block_tea_key_transform: PASS");
        else
            $display("tb_block_tea_key_transform: FAIL");
        $finish;
    end

endmodule
